>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the peak meter RTL.
// Active in simulation; they expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

>>> hw/rtl/apmb_pkg.sv
// Shared types and constants of the audio peak meter.
// No dependencies; used by apmb_back and the top level.
`default_nettype none

package apmb_pkg;

  localparam int unsigned LEVEL_W         = 19;
  localparam int unsigned LEVEL_FRAC_BITS = 8;
  localparam int unsigned OUT_DATA_W      = ((LEVEL_W + 7) / 8) * 8;
  localparam int unsigned LOG_FRAC_BITS   = 16;
  localparam int unsigned LOG_MANT_W      = 32;
  localparam int unsigned LEAD_W          = 5;
  localparam int unsigned NORM_STEPS      = 5;
  localparam int unsigned STEP_CNT_W      = 4;
  localparam int unsigned DEPTH_W         = 5;
  localparam int unsigned STEP_W          = 15;
  localparam int unsigned CFG_IDX_W       = 1;
  localparam int unsigned CFG_DATA_W      = 15;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam int unsigned DB_W    = 27;
  localparam int unsigned MUL_A_W = 22;
  localparam int unsigned PROD_W  = MUL_A_W + DB_W;

  localparam logic [DB_W-1:0] DB_PER_OCTAVE_Q24 = 27'd101008905;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_DEPTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETURN_STEP = 1'd1;

  localparam logic [DEPTH_W-1:0] BIT_DEPTH_RESET = 5'd16;
  localparam logic [STEP_W-1:0]  RETURN_STEP_RESET = 15'd0;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MINUS_INF =
    LEVEL_W'(-999 * (1 << LEVEL_FRAC_BITS));
  localparam logic signed [LEVEL_W-1:0] LEVEL_MINUS_60 =
    LEVEL_W'(-60 * (1 << LEVEL_FRAC_BITS));

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_NORM,
    BK_LOG,
    BK_SCALE_PK,
    BK_SCALE_DR,
    BK_DR_FIN,
    BK_UPDATE
  } back_state_e;

  typedef struct packed {
    logic [DEPTH_W-1:0] bit_depth;
    logic [STEP_W-1:0]  return_step;
  } meter_cfg_t;

  typedef struct packed {
    logic               hold;
    logic [LEVEL_W-1:0] level;
  } meter_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/apmb_front.sv
// Front end of the peak meter: takes samples and tracks the block maximum.
// Pushes the maximum into the block queue on the last sample of a block.
`default_nettype none

module apmb_front #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  input  wire logic [SAMPLE_WIDTH-1:0] in_sample_i,
  input  wire logic                    in_last_i,
  output      logic                    in_ready_o,
  input  wire logic                    q_full_i,
  output      logic                    q_push_o,
  output      logic [SAMPLE_WIDTH-1:0] q_data_o
);

  logic [SAMPLE_WIDTH-1:0] run_max_q, run_max_d;
  logic [SAMPLE_WIDTH-1:0] mag;
  logic [SAMPLE_WIDTH-1:0] cur_max;
  logic                    accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // The most negative sample maps to 2^(SAMPLE_WIDTH-1), which still fits.
  assign mag     = in_sample_i[SAMPLE_WIDTH-1] ? (~in_sample_i + 1'b1) : in_sample_i;
  assign cur_max = (mag > run_max_q) ? mag : run_max_q;

  assign q_push_o = accept && in_last_i;
  assign q_data_o = cur_max;

  always_comb begin
    run_max_d = run_max_q;
    if (accept) begin
      run_max_d = in_last_i ? '0 : cur_max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_max_q <= '0;
    end else begin
      run_max_q <= run_max_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/apmb_fifo.sv
// Short queue of block maxima between the front and the back end.
// Generic register queue; no package dependency.
`default_nettype none

module apmb_fifo #(
  parameter int unsigned DATA_W = 24,
  parameter int unsigned DEPTH  = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  output      logic              full_o,
  input  wire logic              pop_i,
  output      logic              valid_o,
  output      logic [DATA_W-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/apmb_back.sv
// Back end of the peak meter: log2 by normalization and repeated squaring,
// dB scaling, level ballistics and the result register. Uses apmb_pkg.
`default_nettype none

module apmb_back #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire apmb_pkg::meter_cfg_t    cfg_i,
  input  wire logic                    q_valid_i,
  input  wire logic [SAMPLE_WIDTH-1:0] q_data_i,
  output      logic                    q_pop_o,
  input  wire logic                    res_ready_i,
  output      logic                    res_valid_o,
  output      apmb_pkg::meter_res_t    res_o
);

  localparam int unsigned MW       = apmb_pkg::LOG_MANT_W;
  localparam int unsigned LW       = apmb_pkg::LEVEL_W;
  localparam int unsigned FB       = apmb_pkg::LOG_FRAC_BITS;
  localparam int unsigned D_W      = 7 + FB;
  localparam int unsigned ROUND_SH = 40 - apmb_pkg::LEVEL_FRAC_BITS;
  localparam int unsigned PAD_W    = LW + 1 - apmb_pkg::STEP_W;

  apmb_pkg::back_state_e state_q, state_d;

  logic [MW-1:0]                        mant_q, mant_d;
  logic [apmb_pkg::LEAD_W-1:0]          lead_q, lead_d;
  logic [apmb_pkg::STEP_CNT_W-1:0]      cnt_q, cnt_d;
  logic [FB-1:0]                        frac_q, frac_d;
  logic                                 zero_q, zero_d;
  logic [apmb_pkg::PROD_W-1:0]          prod_q, prod_d;
  logic                                 neg_q, neg_d;
  logic signed [LW-1:0]                 peak_q, peak_d;
  logic signed [LW-1:0]                 dyn_q, dyn_d;
  logic signed [LW-1:0]                 shown_q, shown_d;
  logic                                 res_valid_q, res_valid_d;
  apmb_pkg::meter_res_t                 res_q, res_d;

  logic [5:0]                           bd_ext, bd_clamp;
  logic [apmb_pkg::LEAD_W-1:0]          ref_exp;
  logic [apmb_pkg::LEAD_W-1:0]          shamt;
  logic                                 top_zero;
  logic [2*MW-1:0]                      sq;
  logic [MW:0]                          sq_sh;
  logic signed [6:0]                    int_part;
  logic signed [D_W-1:0]                d_val, d_neg;
  logic [apmb_pkg::MUL_A_W-1:0]         d_mag, mul_a;
  logic signed [LW-1:0]                 rise_lvl, new_shown;
  logic signed [LW:0]                   dec_lvl;
  logic                                 rise, hold;

  function automatic logic signed [LW-1:0] finish(input logic [apmb_pkg::PROD_W-1:0] p,
                                                  input logic n);
    logic [apmb_pkg::PROD_W:0] sum;
    logic [LW-1:0]             v;
    sum = {1'b0, p} + ((apmb_pkg::PROD_W + 1)'(1) << (ROUND_SH - 1));
    v   = LW'(sum >> ROUND_SH);
    return n ? -$signed(v) : $signed(v);
  endfunction

  // Bit depth below 2 acts as 2, above the sample width as the sample width.
  assign bd_ext   = {1'b0, cfg_i.bit_depth};
  assign bd_clamp = (bd_ext < 6'd2) ? 6'd2 :
                    (bd_ext > 6'(SAMPLE_WIDTH)) ? 6'(SAMPLE_WIDTH) : bd_ext;
  assign ref_exp  = apmb_pkg::LEAD_W'(bd_clamp - 6'd1);

  assign shamt    = apmb_pkg::LEAD_W'(5'd16 >> cnt_q);
  assign top_zero = ((mant_q >> (6'(MW) - {1'b0, shamt})) == '0);

  assign sq    = mant_q * mant_q;
  assign sq_sh = sq[2*MW-1:MW-1];

  assign int_part = $signed({2'b00, lead_q}) - $signed({2'b00, ref_exp});
  assign d_val    = {int_part, frac_q};
  assign d_neg    = -d_val;
  assign d_mag    = d_val[D_W-1] ? apmb_pkg::MUL_A_W'(d_neg) : apmb_pkg::MUL_A_W'(d_val);
  assign mul_a    = (state_q == apmb_pkg::BK_SCALE_PK) ? d_mag :
                    apmb_pkg::MUL_A_W'({ref_exp, {FB{1'b0}}});

  assign rise      = (peak_q > shown_q);
  assign rise_lvl  = (peak_q > 0) ? '0 : peak_q;
  assign new_shown = rise ? rise_lvl : shown_q;
  assign hold      = rise && (peak_q >= apmb_pkg::LEVEL_MINUS_60);
  assign dec_lvl   = $signed({new_shown[LW-1], new_shown}) -
                     $signed({{PAD_W{1'b0}}, cfg_i.return_step});

  assign q_pop_o     = (state_q == apmb_pkg::BK_IDLE) && q_valid_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    mant_d      = mant_q;
    lead_d      = lead_q;
    cnt_d       = cnt_q;
    frac_d      = frac_q;
    zero_d      = zero_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    peak_d      = peak_q;
    dyn_d       = dyn_q;
    shown_d     = shown_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;

    unique case (state_q)
      apmb_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          mant_d  = MW'(q_data_i);
          lead_d  = apmb_pkg::LEAD_W'(MW - 1);
          zero_d  = (q_data_i == '0);
          cnt_d   = '0;
          state_d = apmb_pkg::BK_NORM;
        end
      end
      apmb_pkg::BK_NORM: begin
        if (top_zero) begin
          mant_d = mant_q << shamt;
          lead_d = lead_q - shamt;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == apmb_pkg::STEP_CNT_W'(apmb_pkg::NORM_STEPS - 1)) begin
          cnt_d   = '0;
          state_d = apmb_pkg::BK_LOG;
        end
      end
      apmb_pkg::BK_LOG: begin
        frac_d = {frac_q[FB-2:0], sq_sh[MW]};
        mant_d = sq_sh[MW] ? sq_sh[MW:1] : sq_sh[MW-1:0];
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == apmb_pkg::STEP_CNT_W'(FB - 1)) begin
          state_d = apmb_pkg::BK_SCALE_PK;
        end
      end
      apmb_pkg::BK_SCALE_PK: begin
        prod_d  = apmb_pkg::PROD_W'(mul_a * apmb_pkg::DB_PER_OCTAVE_Q24);
        neg_d   = d_val[D_W-1];
        state_d = apmb_pkg::BK_SCALE_DR;
      end
      apmb_pkg::BK_SCALE_DR: begin
        peak_d  = zero_q ? apmb_pkg::LEVEL_MINUS_INF : finish(prod_q, neg_q);
        prod_d  = apmb_pkg::PROD_W'(mul_a * apmb_pkg::DB_PER_OCTAVE_Q24);
        neg_d   = 1'b0;
        state_d = apmb_pkg::BK_DR_FIN;
      end
      apmb_pkg::BK_DR_FIN: begin
        dyn_d   = finish(prod_q, 1'b0);
        state_d = apmb_pkg::BK_UPDATE;
      end
      apmb_pkg::BK_UPDATE: begin
        if (!res_valid_q || res_ready_i) begin
          res_d.level = new_shown;
          res_d.hold  = hold;
          res_valid_d = 1'b1;
          shown_d     = new_shown;
          if (peak_q < new_shown) begin
            shown_d = (new_shown > -dyn_q) ? dec_lvl[LW-1:0] : apmb_pkg::LEVEL_MINUS_INF;
          end
          state_d = apmb_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = apmb_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mant_d_reg: begin
      mant_q <= mant_d;
      lead_q <= lead_d;
      frac_q <= frac_d;
      zero_q <= zero_d;
      prod_q <= prod_d;
      neg_q  <= neg_d;
      peak_q <= peak_d;
      dyn_q  <= dyn_d;
      res_q  <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apmb_pkg::BK_IDLE;
      cnt_q       <= '0;
      shown_q     <= apmb_pkg::LEVEL_MINUS_60;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      shown_q     <= shown_d;
      res_valid_q <= res_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/audio_peak_meter_ballistics_unit.sv
// Top level of the audio peak meter with decay ballistics.
// Instantiates apmb_front, apmb_fifo and apmb_back; uses apmb_pkg and assert_macros.svh.
//
// Samples are taken at one item per cycle; a block of any length streams in without
// stalls as long as the four-entry block queue has room. Each block end is then worked
// off by the back end one block at a time (a fetch of the block maximum, five normalizing
// shift steps, sixteen squaring steps of the 32x32 log2 multiplier, scaling and rounding
// on the dB multiplier in BK_SCALE_PK, BK_SCALE_DR and BK_DR_FIN, then the level update),
// so short blocks eventually fill the queue and stall the input. Results leave through a
// registered output, held during the next block; the level update waits until it is taken.
`default_nettype none

`include "assert_macros.svh"

module audio_peak_meter_ballistics_unit #(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [apmb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [apmb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // sample
  input  wire logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // meter_level
  output      logic [apmb_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // hold_update
  output      logic                                m_axis_tuser
);

  apmb_pkg::meter_cfg_t cfg_q, cfg_d;
  apmb_pkg::meter_res_t res;

  logic                    q_push, q_full, q_valid, q_pop;
  logic [SAMPLE_WIDTH-1:0] q_push_data, q_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        apmb_pkg::CFG_BIT_DEPTH:   cfg_d.bit_depth   = cfg_data_i[apmb_pkg::DEPTH_W-1:0];
        apmb_pkg::CFG_RETURN_STEP: cfg_d.return_step = cfg_data_i[apmb_pkg::STEP_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_depth   <= apmb_pkg::BIT_DEPTH_RESET;
      cfg_q.return_step <= apmb_pkg::RETURN_STEP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  apmb_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_sample_i(s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  apmb_fifo #(
    .DATA_W(SAMPLE_WIDTH),
    .DEPTH (apmb_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_push_data),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .data_o     (q_data)
  );

  apmb_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_data_i   (q_data),
    .q_pop_o    (q_pop),
    .res_ready_i(m_axis_tready),
    .res_valid_o(m_axis_tvalid),
    .res_o      (res)
  );

  assign m_axis_tdata = apmb_pkg::OUT_DATA_W'(res.level);
  assign m_axis_tuser = res.hold;

  `ASSERT_ALWAYS(a_level_not_above_0db, clk_i, rst_ni,
    !m_axis_tvalid || res.level[apmb_pkg::LEVEL_W-1] || (res.level == '0),
    "meter level above 0 dB")

  `ASSERT_IMPLIES(a_hold_above_floor, clk_i, rst_ni, m_axis_tvalid && res.hold,
    $signed(res.level) >= apmb_pkg::LEVEL_MINUS_60, "hold update below -60 dB")

  `ASSERT_IMPLIES(a_pop_only_when_queued, clk_i, rst_ni, q_pop, q_valid,
    "back end took a block from an empty queue")

endmodule

`default_nettype wire
